// ===== rtl/vgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// vgcd_pkg
// Shared types and constants of the voxel grid centroid downsampler.
// ----------------------------------------------------------------------------
package vgcd_pkg;
  localparam int MAX_VOXELS = 1024;
  localparam int INDEX_BITS = 16;
  localparam int COUNT_BITS = 24;
  localparam int ADDR_BITS  = $clog2(MAX_VOXELS);
  localparam int TOTAL_BITS = $clog2(MAX_VOXELS + 1);
  localparam int KEY_BITS   = 3 * INDEX_BITS;
  localparam int SUM_BITS   = 32 + COUNT_BITS;
  localparam int QDEPTH     = 2;

  localparam logic [2:0] ST_NEW   = 3'd0;
  localparam logic [2:0] ST_ACC   = 3'd1;
  localparam logic [2:0] ST_RANGE = 3'd2;
  localparam logic [2:0] ST_TFULL = 3'd3;
  localparam logic [2:0] ST_CFULL = 3'd4;
  localparam logic [2:0] ST_CENT  = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  localparam logic [1:0] CFG_OX  = 2'd0;
  localparam logic [1:0] CFG_OY  = 2'd1;
  localparam logic [1:0] CFG_OZ  = 2'd2;
  localparam logic [1:0] CFG_INV = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic                         drain;
    logic                         oor;
    logic [INDEX_BITS-1:0]        ix;
    logic [INDEX_BITS-1:0]        iy;
    logic [INDEX_BITS-1:0]        iz;
    logic signed [31:0]           x;
    logic signed [31:0]           y;
    logic signed [31:0]           z;
  } item_t;
endpackage

// ===== rtl/vgcd_front.sv =====
// ----------------------------------------------------------------------------
// vgcd_front
// Accepts points, quantizes them to voxel indices over three axes (one axis
// at a time through one multiplier) and pushes classified items into a queue.
// ----------------------------------------------------------------------------
module vgcd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic signed [31:0]   in_px,
  input  logic signed [31:0]   in_py,
  input  logic signed [31:0]   in_pz,
  input  logic signed [31:0]   origin_x,
  input  logic signed [31:0]   origin_y,
  input  logic signed [31:0]   origin_z,
  input  logic [31:0]          inv_cell_size,
  output logic                 q_valid,
  input  logic                 q_ready,
  output vgcd_pkg::item_t      q_item
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_WAIT, S_CHK, S_PUSH} state_t;
  state_t state_r;
  logic [1:0] axis_r;
  vgcd_pkg::item_t item_r;
  logic [31:0] diff_r;
  logic [63:0] prod_r;
  logic neg_r;

  logic signed [31:0] coord, orig;
  logic signed [32:0] diff;
  always_comb begin
    case (axis_r)
      2'd0: begin coord = item_r.x; orig = origin_x; end
      2'd1: begin coord = item_r.y; orig = origin_y; end
      default: begin coord = item_r.z; orig = origin_z; end
    endcase
    diff = 33'(coord) - 33'(orig);
  end

  logic [vgcd_pkg::INDEX_BITS-1:0] qidx;
  logic qbad;
  always_comb begin
    qidx = prod_r[32 +: vgcd_pkg::INDEX_BITS];
    qbad = neg_r || (prod_r[63:32] >> vgcd_pkg::INDEX_BITS) != '0;
    if (inv_cell_size == '0) begin
      qidx = '0;
      qbad = 1'b0;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign q_valid  = (state_r == S_PUSH);
  assign q_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      axis_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) begin
          item_r.drain <= in_mode;
          item_r.oor   <= 1'b0;
          item_r.ix <= '0; item_r.iy <= '0; item_r.iz <= '0;
          item_r.x <= in_px; item_r.y <= in_py; item_r.z <= in_pz;
          axis_r  <= '0;
          state_r <= in_mode ? S_PUSH : S_MUL;
        end
        S_MUL: begin
          diff_r  <= diff[31:0];
          neg_r   <= diff[32];
          state_r <= S_WAIT;
        end
        // wait while prod_r picks up the new diff_r
        S_WAIT: state_r <= S_CHK;
        S_CHK: begin
          case (axis_r)
            2'd0: item_r.ix <= qidx;
            2'd1: item_r.iy <= qidx;
            default: item_r.iz <= qidx;
          endcase
          if (qbad) item_r.oor <= 1'b1;
          if (axis_r == 2'd2) begin
            state_r <= S_PUSH;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_MUL;
          end
        end
        S_PUSH: if (q_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // one multiplier: 32 x 32 unsigned, registered
  always_ff @(posedge clk) begin
    prod_r <= 64'(diff_r) * 64'(inv_cell_size);
  end
endmodule

// ===== rtl/vgcd_queue.sv =====
// ----------------------------------------------------------------------------
// vgcd_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module vgcd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  vgcd_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output vgcd_pkg::item_t rd_item
);
  vgcd_pkg::item_t mem_r [vgcd_pkg::QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;
  assign wr_ready = cnt_r != 2'(vgcd_pkg::QDEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_item;
        wp_r <= ~wp_r;
      end
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule

// ===== rtl/vgcd_back.sv =====
// ----------------------------------------------------------------------------
// vgcd_back
// Table engine: scans keys one entry at a time, updates counts and sums, and on
// drain divides each sum by the count with a bit-serial restoring divider.
// ----------------------------------------------------------------------------
module vgcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  vgcd_pkg::item_t      q_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [15:0]          out_cell_x,
  output logic [15:0]          out_cell_y,
  output logic [15:0]          out_cell_z,
  output logic signed [31:0]   out_mean_x,
  output logic signed [31:0]   out_mean_y,
  output logic signed [31:0]   out_mean_z,
  output logic [23:0]          out_members,
  output logic                 out_last
);
  localparam int AB = vgcd_pkg::ADDR_BITS;
  localparam int TB = vgcd_pkg::TOTAL_BITS;
  localparam int KB = vgcd_pkg::KEY_BITS;
  localparam int SB = vgcd_pkg::SUM_BITS;
  localparam int CB = vgcd_pkg::COUNT_BITS;
  localparam int IB = vgcd_pkg::INDEX_BITS;
  localparam logic [CB-1:0] CMAX = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_SCAN_C, S_UPD, S_DRD, S_DRW, S_DIV, S_DSET, S_OUT
  } state_t;
  state_t state_r;

  logic [KB-1:0] key_mem [vgcd_pkg::MAX_VOXELS];
  logic [CB-1:0] cnt_mem [vgcd_pkg::MAX_VOXELS];
  logic [SB-1:0] sx_mem  [vgcd_pkg::MAX_VOXELS];
  logic [SB-1:0] sy_mem  [vgcd_pkg::MAX_VOXELS];
  logic [SB-1:0] sz_mem  [vgcd_pkg::MAX_VOXELS];

  logic [TB-1:0] total_r, drain_r, scan_r;
  vgcd_pkg::item_t it_r;
  logic [KB-1:0] key_rd_r;
  logic [CB-1:0] cnt_rd_r;
  logic [SB-1:0] sx_rd_r, sy_rd_r, sz_rd_r;
  logic [AB-1:0] raddr_r;

  logic [KB-1:0] key;
  assign key = {it_r.ix, it_r.iy, it_r.iz};

  // divider
  logic [1:0] dax_r;
  logic [6:0] dbit_r;
  logic [SB-1:0] dnum_r, dq_r;
  logic [CB:0] drem_r;
  logic dneg_r;
  logic [CB-1:0] dden_r;
  logic [CB:0] trial;
  logic [SB-1:0] cur_sum;
  always_comb begin
    trial = {drem_r[CB-1:0], dnum_r[SB-1]};
    case (dax_r)
      2'd0: cur_sum = sx_rd_r;
      2'd1: cur_sum = sy_rd_r;
      default: cur_sum = sz_rd_r;
    endcase
  end

  logic [2:0]  st_r;
  logic [15:0] cx_r, cy_r, cz_r;
  logic [31:0] mx_r, my_r, mz_r;
  logic [23:0] mem_r;
  logic        last_r;

  assign q_ready    = (state_r == S_IDLE);
  assign out_valid  = (state_r == S_OUT);
  assign out_status = st_r;
  assign out_cell_x = cx_r;
  assign out_cell_y = cy_r;
  assign out_cell_z = cz_r;
  assign out_mean_x = mx_r;
  assign out_mean_y = my_r;
  assign out_mean_z = mz_r;
  assign out_members = mem_r;
  assign out_last   = last_r;

  logic mem_we;
  logic [AB-1:0] waddr;
  logic [KB-1:0] wkey;
  logic [CB-1:0] wcnt;
  logic [SB-1:0] wsx, wsy, wsz;

  always_ff @(posedge clk) begin
    key_rd_r <= key_mem[raddr_r];
    cnt_rd_r <= cnt_mem[raddr_r];
    sx_rd_r  <= sx_mem[raddr_r];
    sy_rd_r  <= sy_mem[raddr_r];
    sz_rd_r  <= sz_mem[raddr_r];
    if (mem_we) begin
      key_mem[waddr] <= wkey;
      cnt_mem[waddr] <= wcnt;
      sx_mem[waddr]  <= wsx;
      sy_mem[waddr]  <= wsy;
      sz_mem[waddr]  <= wsz;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    waddr  = scan_r[AB-1:0];
    wkey   = key;
    wcnt   = cnt_rd_r + CB'(1);
    wsx    = sx_rd_r + SB'(it_r.x);
    wsy    = sy_rd_r + SB'(it_r.y);
    wsz    = sz_rd_r + SB'(it_r.z);
    if (state_r == S_UPD) begin
      mem_we = 1'b1;
      if (scan_r == total_r) begin
        wcnt = CB'(1);
        wsx = SB'(it_r.x); wsy = SB'(it_r.y); wsz = SB'(it_r.z);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      total_r <= '0;
      drain_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          cx_r <= '0; cy_r <= '0; cz_r <= '0;
          mx_r <= '0; my_r <= '0; mz_r <= '0;
          mem_r <= '0; last_r <= 1'b0;
          scan_r <= '0;
          raddr_r <= '0;
          if (q_item.drain) begin
            if (total_r == '0 || drain_r >= total_r) begin
              st_r <= vgcd_pkg::ST_EMPTY;
              state_r <= S_OUT;
            end else begin
              raddr_r <= drain_r[AB-1:0];
              state_r <= S_DRD;
            end
          end else if (q_item.oor) begin
            st_r <= vgcd_pkg::ST_RANGE;
            state_r <= S_OUT;
          end else begin
            cx_r <= q_item.ix; cy_r <= q_item.iy; cz_r <= q_item.iz;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // raddr_r == scan_r here; data arrives next cycle
          if (scan_r == total_r) begin
            if (total_r == TB'(vgcd_pkg::MAX_VOXELS)) begin
              st_r <= vgcd_pkg::ST_TFULL;
              state_r <= S_OUT;
            end else begin
              st_r <= vgcd_pkg::ST_NEW;
              mem_r <= 24'(1);
              state_r <= S_UPD;
            end
          end else begin
            state_r <= S_SCAN_W;
          end
        end
        S_SCAN_W: state_r <= S_SCAN_C;
        S_SCAN_C: begin
          if (key_rd_r == key) begin
            if (cnt_rd_r == CMAX) begin
              st_r <= vgcd_pkg::ST_CFULL;
              mem_r <= 24'(cnt_rd_r);
              state_r <= S_OUT;
            end else begin
              st_r <= vgcd_pkg::ST_ACC;
              mem_r <= 24'(cnt_rd_r + CB'(1));
              state_r <= S_UPD;
            end
          end else begin
            scan_r  <= scan_r + TB'(1);
            raddr_r <= AB'(scan_r + TB'(1));
            state_r <= S_SCAN;
          end
        end
        S_UPD: begin
          if (scan_r == total_r) total_r <= total_r + TB'(1);
          state_r <= S_OUT;
        end
        S_DRD: state_r <= S_DRW;
        S_DRW: begin
          cx_r <= key_rd_r[2*IB +: IB];
          cy_r <= key_rd_r[IB +: IB];
          cz_r <= key_rd_r[0 +: IB];
          mem_r <= 24'(cnt_rd_r);
          dden_r <= (cnt_rd_r == '0) ? CB'(1) : cnt_rd_r;
          st_r <= vgcd_pkg::ST_CENT;
          dax_r <= 2'd0;
          state_r <= S_DSET;
        end
        S_DSET: begin
          dneg_r <= cur_sum[SB-1];
          dnum_r <= cur_sum[SB-1] ? SB'(-cur_sum) : cur_sum;
          drem_r <= '0;
          dq_r   <= '0;
          dbit_r <= 7'(SB);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (dbit_r == '0) begin
            case (dax_r)
              2'd0: mx_r <= dneg_r ? 32'(-dq_r) : 32'(dq_r);
              2'd1: my_r <= dneg_r ? 32'(-dq_r) : 32'(dq_r);
              default: mz_r <= dneg_r ? 32'(-dq_r) : 32'(dq_r);
            endcase
            if (dax_r == 2'd2) begin
              if (drain_r + TB'(1) == total_r) begin
                last_r <= 1'b1;
                total_r <= '0;
                drain_r <= '0;
              end else begin
                drain_r <= drain_r + TB'(1);
              end
              state_r <= S_OUT;
            end else begin
              dax_r <= dax_r + 2'd1;
              state_r <= S_DSET;
            end
          end else begin
            dnum_r <= {dnum_r[SB-2:0], 1'b0};
            if (trial >= {1'b0, dden_r}) begin
              drem_r <= trial - {1'b0, dden_r};
              dq_r   <= {dq_r[SB-2:0], 1'b1};
            end else begin
              drem_r <= trial;
              dq_r   <= {dq_r[SB-2:0], 1'b0};
            end
            dbit_r <= dbit_r - 7'd1;
          end
        end
        S_OUT: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= TB'(vgcd_pkg::MAX_VOXELS))
    else $error("entry count beyond table size");
  a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r <= total_r)
    else $error("drain index past entry count");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(st_r))
    else $error("result dropped before transfer");
  a_last_cent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == vgcd_pkg::ST_CENT)
    else $error("last flag outside centroid");
endmodule

// ===== rtl/voxel_grid_centroid_downsample_unit.sv =====
// ----------------------------------------------------------------------------
// voxel_grid_centroid_downsample_unit
// Voxel grid filter with centroid downsampling over a 1024 entry table.
// ----------------------------------------------------------------------------
// One item is in the back end at a time. A point is quantized in the front one
// axis at a time, three axes through one shared multiplier, and the back scans
// table entries one at a time, since keys are read serially from a memory with
// one read port. A drain item divides its sums in the bit-serial divider.
// The front may quantize the next point while the back works on the last.
module voxel_grid_centroid_downsample_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic signed [31:0]   in_px,
  input  logic signed [31:0]   in_py,
  input  logic signed [31:0]   in_pz,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_status,
  output logic [15:0]          out_cell_x,
  output logic [15:0]          out_cell_y,
  output logic [15:0]          out_cell_z,
  output logic signed [31:0]   out_mean_x,
  output logic signed [31:0]   out_mean_y,
  output logic signed [31:0]   out_mean_z,
  output logic [23:0]          out_members,
  output logic                 out_last,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  logic signed [31:0] ox_r, oy_r, oz_r;
  logic [31:0] inv_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0; oy_r <= '0; oz_r <= '0; inv_r <= 32'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        vgcd_pkg::CFG_OX:  ox_r <= cfg_data;
        vgcd_pkg::CFG_OY:  oy_r <= cfg_data;
        vgcd_pkg::CFG_OZ:  oz_r <= cfg_data;
        vgcd_pkg::CFG_INV: inv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic fq_valid, fq_ready, bq_valid, bq_ready;
  vgcd_pkg::item_t fq_item, bq_item;

  vgcd_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_mode, .in_px, .in_py, .in_pz,
    .origin_x(ox_r), .origin_y(oy_r), .origin_z(oz_r), .inv_cell_size(inv_r),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  vgcd_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
    .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_item(bq_item)
  );

  vgcd_back u_back (
    .clk, .rst_n, .q_valid(bq_valid), .q_ready(bq_ready), .q_item(bq_item),
    .out_valid, .out_ready, .out_status, .out_cell_x, .out_cell_y, .out_cell_z,
    .out_mean_x, .out_mean_y, .out_mean_z, .out_members, .out_last
  );
endmodule
